@@ design/utc_offset_parser_top_defines.svh @@
// ----------------------------------------------------------------------------
// UTC offset parser assertion macros
// Shorthand for the concurrent assertions of the port checker.
// ----------------------------------------------------------------------------
`ifndef UTC_OFFSET_PARSER_TOP_DEFINES_SVH
`define UTC_OFFSET_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define UOP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UOP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after a reset cycle.
`define UOP_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

@@ design/uop_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTC offset parser package
// Character codes, phase encoding, scale constants and the record that
// passes a finished offset from the parser to the result stage.
// ----------------------------------------------------------------------------
package uop_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [6:0] RADIX    = 7'd10;

  localparam int TDATA_W  = 72;
  localparam int MICROS_W = 40;

  localparam logic signed [MICROS_W-1:0] US_PER_HOUR   = 40'sd3600000000;
  localparam logic signed [MICROS_W-1:0] US_PER_MINUTE = 40'sd60000000;
  localparam logic signed [MICROS_W-1:0] US_PER_SECOND = 40'sd1000000;

  typedef enum logic [3:0] {
    PH_SIGN,
    PH_H1,
    PH_H2,
    PH_SEP,
    PH_M1,
    PH_M2,
    PH_SEP2,
    PH_S1,
    PH_S2,
    PH_DONE,
    PH_FAIL
  } uop_phase_t;

  typedef struct packed {
    logic              accepted;
    logic signed [7:0] hours;
    logic signed [7:0] minutes;
    logic signed [7:0] seconds;
    logic [3:0]        consumed;
  } uop_done_t;

endpackage

@@ design/utc_offset_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTC offset parser
// Parses a [+-]HH[[:]MM[:SS]] offset one character per beat and reports the
// signed fields and the offset in microseconds on the last character.
// ----------------------------------------------------------------------------
//   channel   dir   payload                         beat marker
//   s_*       in    one character                   tlast = final character
//   m_*       out   hours..offset_micros, accepted  one beat per text
//
// One character is taken per cycle, back to back, with no gaps between texts,
// unless a last character waits for room in a full done register. A result
// beat passes the input register, the parser/done register, then the output
// register after the microsecond scaling. Reset is synchronous and clears the
// phase machine and every valid flag. A stalled output holds its beat; the done
// register and the input register keep taking characters until both are full.
// ----------------------------------------------------------------------------
module utc_offset_parser_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] char_code
  input  logic                        s_tlast,   // last_char
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [7:0] hours, [15:8] minutes, [23:16] seconds, [27:24] consumed_length,
  // [67:28] offset_micros, [71:68] zero
  output logic [uop_pkg::TDATA_W-1:0] m_tdata,
  output logic                        m_tuser    // accepted
);
  import uop_pkg::*;

  logic      done_valid;
  logic      done_ready;
  uop_done_t done;

  uop_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done       (done)
  );

  uop_result u_result (
    .clk        (clk),
    .rst        (rst),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done       (done),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

@@ design/uop_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTC offset parser front end
// Input register, character phase machine with digit accumulators, and the
// register that holds a finished offset until the result stage takes it.
// ----------------------------------------------------------------------------
module uop_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  output logic             done_valid,
  input  logic             done_ready,
  output uop_pkg::uop_done_t done
);
  import uop_pkg::*;

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;
  logic       parse_take;

  uop_phase_t phase, phase_next;
  logic       negative_sign, negative_sign_next;
  logic       colon_seen, colon_seen_next;
  logic [3:0] held_digit, held_digit_next;
  logic [6:0] hour_value, hour_value_next;
  logic [6:0] minute_value, minute_value_next;
  logic [6:0] second_value, second_value_next;
  logic [3:0] consumed_count, consumed_count_next;

  logic       is_digit;
  logic [3:0] digit;
  logic [6:0] pair_value;
  logic       accepted;
  uop_done_t  done_next;

  // A character that ends a text needs room in the done register.
  assign parse_take = in_valid && (!in_last || !done_valid || done_ready);
  assign s_tready   = !in_valid || parse_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (parse_take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  assign is_digit   = (in_char >= CH_ZERO) && (in_char <= CH_ZERO + 8'd9);
  assign digit      = in_char[3:0];
  assign pair_value = {3'b000, held_digit} * RADIX + {3'b000, digit};

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SIGN: begin
        phase_next = (in_char == CH_PLUS || in_char == CH_MINUS) ? PH_H1 : PH_FAIL;
      end
      PH_H1:   phase_next = is_digit ? PH_H2 : PH_FAIL;
      PH_H2:   phase_next = is_digit ? PH_SEP : PH_FAIL;
      PH_SEP: begin
        if (in_char == CH_COLON) begin
          phase_next = PH_M1;
        end else if (is_digit) begin
          phase_next = PH_M2;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_M1:   phase_next = is_digit ? PH_M2 : PH_DONE;
      PH_M2:   phase_next = (is_digit && colon_seen) ? PH_SEP2 : PH_DONE;
      PH_SEP2: phase_next = (in_char == CH_COLON) ? PH_S1 : PH_DONE;
      PH_S1:   phase_next = is_digit ? PH_S2 : PH_DONE;
      PH_S2:   phase_next = PH_DONE;
      default: phase_next = phase;
    endcase
  end

  always_comb begin
    negative_sign_next  = negative_sign;
    colon_seen_next     = colon_seen;
    held_digit_next     = held_digit;
    hour_value_next     = hour_value;
    minute_value_next   = minute_value;
    second_value_next   = second_value;
    consumed_count_next = consumed_count;
    case (phase)
      PH_SIGN: begin
        if (in_char == CH_PLUS || in_char == CH_MINUS) begin
          negative_sign_next = (in_char == CH_MINUS);
        end
      end
      PH_H1: begin
        if (is_digit) begin
          held_digit_next = digit;
        end
      end
      PH_H2: begin
        if (is_digit) begin
          hour_value_next     = pair_value;
          consumed_count_next = 4'd3;
        end
      end
      PH_SEP: begin
        if (in_char == CH_COLON) begin
          colon_seen_next     = 1'b1;
          consumed_count_next = 4'd4;
        end else if (is_digit) begin
          held_digit_next = digit;
        end
      end
      PH_M1, PH_S1: begin
        if (is_digit) begin
          held_digit_next = digit;
        end
      end
      PH_M2: begin
        if (is_digit) begin
          minute_value_next   = pair_value;
          consumed_count_next = consumed_count + 4'd2;
        end
      end
      PH_SEP2: begin
        if (in_char == CH_COLON) begin
          consumed_count_next = consumed_count + 4'd1;
        end
      end
      PH_S2: begin
        if (is_digit) begin
          second_value_next   = pair_value;
          consumed_count_next = consumed_count + 4'd2;
        end
      end
      default: begin
      end
    endcase
  end

  assign accepted = !(phase_next == PH_SIGN || phase_next == PH_H1 ||
                      phase_next == PH_H2 || phase_next == PH_FAIL);

  always_comb begin
    done_next = '0;
    if (accepted) begin
      done_next.accepted = 1'b1;
      done_next.hours    = negative_sign_next ? 8'sd0 - $signed({1'b0, hour_value_next})
                                              : $signed({1'b0, hour_value_next});
      done_next.minutes  = negative_sign_next ? 8'sd0 - $signed({1'b0, minute_value_next})
                                              : $signed({1'b0, minute_value_next});
      done_next.seconds  = negative_sign_next ? 8'sd0 - $signed({1'b0, second_value_next})
                                              : $signed({1'b0, second_value_next});
      done_next.consumed = consumed_count_next;
    end
  end

  // The last character of a text returns the machine to its idle state.
  always_ff @(posedge clk) begin
    if (rst || (parse_take && in_last)) begin
      phase          <= PH_SIGN;
      negative_sign  <= 1'b0;
      colon_seen     <= 1'b0;
      held_digit     <= '0;
      hour_value     <= '0;
      minute_value   <= '0;
      second_value   <= '0;
      consumed_count <= '0;
    end else if (parse_take) begin
      phase          <= phase_next;
      negative_sign  <= negative_sign_next;
      colon_seen     <= colon_seen_next;
      held_digit     <= held_digit_next;
      hour_value     <= hour_value_next;
      minute_value   <= minute_value_next;
      second_value   <= second_value_next;
      consumed_count <= consumed_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_valid <= 1'b0;
    end else if (parse_take && in_last) begin
      done_valid <= 1'b1;
    end else if (done_ready) begin
      done_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (parse_take && in_last) begin
      done <= done_next;
    end
  end

endmodule

@@ design/uop_result.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTC offset parser result stage
// Scales the signed fields to microseconds and holds the output beat.
// ----------------------------------------------------------------------------
module uop_result (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      done_valid,
  output logic                      done_ready,
  input  uop_pkg::uop_done_t        done,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [uop_pkg::TDATA_W-1:0] m_tdata,
  output logic                      m_tuser
);
  import uop_pkg::*;

  logic signed [MICROS_W-1:0] hours_ext, minutes_ext, seconds_ext;
  logic signed [MICROS_W-1:0] hour_us, minute_us, second_us, micros;

  assign done_ready = !m_tvalid || m_tready;

  assign hours_ext   = {{(MICROS_W-8){done.hours[7]}}, done.hours};
  assign minutes_ext = {{(MICROS_W-8){done.minutes[7]}}, done.minutes};
  assign seconds_ext = {{(MICROS_W-8){done.seconds[7]}}, done.seconds};

  // Constant multipliers; the operands are 8-bit values sign-extended.
  assign hour_us   = hours_ext * US_PER_HOUR;
  assign minute_us = minutes_ext * US_PER_MINUTE;
  assign second_us = seconds_ext * US_PER_SECOND;
  assign micros    = hour_us + minute_us + second_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done_valid && done_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      m_tuser <= done.accepted;
      m_tdata <= {4'b0000, micros, done.consumed, done.seconds, done.minutes, done.hours};
    end
  end

endmodule

@@ design/uop_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTC offset parser port checker
// Watches the ports of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
`include "utc_offset_parser_top_defines.svh"

module uop_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [uop_pkg::TDATA_W-1:0] m_tdata,
  input logic                        m_tuser
);

  `UOP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output beat changed while stalled")

  `UOP_ASSERT_RST(a_reset_idle, !m_tvalid && s_tready, "block not idle after reset")

  `UOP_ASSERT_IMP(a_reject_zero, m_tvalid && !m_tuser, m_tdata == '0, "rejected text carries nonzero fields")

  `UOP_ASSERT_IMP(a_length_range, m_tvalid && m_tuser, m_tdata[27:24] >= 4'd3 && m_tdata[27:24] <= 4'd9, "consumed length out of range")

endmodule

bind utc_offset_parser_top uop_checker u_checker (.*);
